>>> hdl/sha256_hash_engine_top_macros.svh
// Assertion macros for the SHA-256 hash engine.
// Used by the top level only; empty bodies when SYNTH is defined.
`ifndef SHA256_HASH_ENGINE_TOP_MACROS_SVH
`define SHA256_HASH_ENGINE_TOP_MACROS_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/sha_pkg.sv
// Shared types, constants and functions of the SHA-256 hash engine.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
  localparam int QueueDepth = 2;

  typedef logic [31:0] word_t;

  // Request passed from the front to the back part
  typedef struct packed {
    logic       finish;
    logic [31:0] data;
    logic [2:0] count;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
  } state_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

>>> hdl/sha_front.sv
// Front part: accepts requests and holds them in a short queue.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front import sha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_ready,
  output req_t q_req
);
  req_t q_mem [QueueDepth];
  req_t in_clamp;
  logic wr_ptr, rd_ptr;
  logic [1:0] level;
  logic push, pop;

  assign in_ready = (level != 2'(QueueDepth));
  assign q_valid  = (level != 2'd0);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_req = q_mem[rd_ptr];

  // Clamp byte count to four
  always_comb begin
    in_clamp = in_req;
    if (in_req.count > 3'd4) in_clamp.count = 3'd4;
  end

  // Store incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_clamp;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      level <= level + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> hdl/sha_back.sv
// Back part: packs bytes, runs the 64-round compression, pads and emits the digest.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  req_t        q_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_index
);
  state_t state, state_next;
  word_t hash [8];
  word_t v [8];
  word_t w [16];
  logic [63:0] bit_len;
  logic [5:0] fill;
  logic [5:0] rnd;
  logic [2:0] bcnt;
  logic [2:0] bidx;
  logic [31:0] data;
  logic finishing, pad_second;
  logic [2:0] emit_idx;
  logic obuf_valid;
  logic [31:0] obuf_word;
  logic [2:0] obuf_idx;

  word_t t1, t2, wn, s0, s1;
  logic take;

  assign q_ready = (state == ST_IDLE);
  assign take = q_valid && q_ready;

  // Round arithmetic
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = s1 + w[9] + s0 + w[0];
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = q_req.finish ? ST_PAD :
                                      ((q_req.count == 3'd0) ? ST_IDLE : ST_LOAD);
      ST_LOAD: if (fill == 6'd63) state_next = ST_ROUND;
               else if (bidx + 3'd1 >= bcnt) state_next = ST_IDLE;
      ST_PAD:  state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!finishing) state_next = (bidx < bcnt) ? ST_LOAD : ST_IDLE;
        else if (pad_second) state_next = ST_PAD;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (!obuf_valid || out_ready)
                 if (emit_idx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register
  assign out_valid = obuf_valid;
  assign out_word  = obuf_word;
  assign out_index = obuf_idx;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bit_len <= '0;
      fill <= '0;
      obuf_valid <= 1'b0;
      emit_idx <= '0;
      finishing <= 1'b0;
      for (int i = 0; i < 8; i++) hash[i] <= init_hash(3'(i));
    end else begin
      state <= state_next;
      // Load or drain the output register
      if (state == ST_EMIT && (!obuf_valid || out_ready)) begin
        obuf_valid <= 1'b1;
      end else if (out_ready) begin
        obuf_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (take) begin
          finishing <= q_req.finish;
          emit_idx <= '0;
        end
        ST_LOAD: begin
          fill <= fill + 6'd1;
          bit_len <= bit_len + 64'd8;
        end
        ST_FOLD: for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
        ST_EMIT: if (!obuf_valid || out_ready) begin
          emit_idx <= emit_idx + 3'd1;
          if (emit_idx == 3'd7) begin
            for (int i = 0; i < 8; i++) hash[i] <= init_hash(3'(i));
            bit_len <= '0;
            fill <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; the schedule window doubles as the block buffer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (take) begin
        data <= q_req.data;
        bcnt <= q_req.count;
        bidx <= '0;
        pad_second <= 1'b0;
      end
      ST_LOAD: begin
        w[fill[5:2]][31 - 8*fill[1:0] -: 8] <= data[31 - 8*bidx -: 8];
        bidx <= bidx + 3'd1;
        if (fill == 6'd63) begin
          for (int i = 0; i < 8; i++) v[i] <= hash[i];
          rnd <= '0;
        end
      end
      ST_PAD: begin
        // Build the padded block in place in the schedule window
        for (int i = 0; i < 64; i++) begin
          logic [7:0] b;
          if (pad_second) b = 8'h00;
          else if (6'(i) < fill) b = w[i/4][31 - 8*(i%4) -: 8];
          else if (6'(i) == fill) b = PadByte;
          else b = 8'h00;
          if (!(fill >= LenPos && !pad_second) && i >= 56)
            b = bit_len[63 - 8*(i-56) -: 8];
          w[i/4][31 - 8*(i%4) -: 8] <= b;
        end
        pad_second <= (fill >= LenPos) && !pad_second;
        for (int i = 0; i < 8; i++) v[i] <= hash[i];
        rnd <= '0;
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wn;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        rnd <= rnd + 6'd1;
      end
      ST_EMIT: if (!obuf_valid || out_ready) begin
        obuf_word <= hash[emit_idx];
        obuf_idx <= emit_idx;
      end
      default: ;
    endcase
  end
endmodule

>>> hdl/sha256_hash_engine_top.sv
// SHA-256 hash engine: absorbs message words and emits eight digest words.
// Channels: s_axis (request in), m_axis (digest out).
// Absorb request: queued in the front part, taken by the back part when
// idle, then packed one byte per cycle; a full block adds the 64 rounds
// and the fold, run by the single round unit.
// Finish request: taken when idle, then one or two compressions of the padded
// block, then eight result words, one per cycle while the receiver takes them.
// Reset restores the initial hash values, clears the bit count and the
// fill position and empties the two-entry queue.
// A stalled receiver holds the output register and the back part; the
// queue keeps accepting until both entries are full.
// Bytes are packed straight into the schedule window, which has no reset;
// only written bytes are ever read.
// Depends on sha_pkg and sha256_hash_engine_top_macros.svh.
`timescale 1ns / 1ps
`include "sha256_hash_engine_top_macros.svh"
module sha256_hash_engine_top import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // message_word[31:0], byte_count[34:32], zero fill
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_axis_tlast   // last_word
);
  req_t in_req, q_req;
  logic q_valid, q_ready;
  logic [31:0] dword;
  logic [2:0] didx;
  logic out_stall, out_take;

  assign in_req = '{finish: s_axis_tuser, data: s_axis_tdata[31:0],
                    count: s_axis_tdata[34:32]};

  sha_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  sha_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_word(dword), .out_index(didx)
  );

  assign m_axis_tdata = {5'd0, didx, dword};
  assign m_axis_tlast = (didx == 3'd7);

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_take  = m_axis_tvalid && m_axis_tready;

  `SHA_ASSERT_NEXT(a_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `SHA_ASSERT_NEXT(a_order, clk, rst, out_take && !m_axis_tlast, !m_axis_tvalid || didx == $past(didx) + 3'd1)
  `SHA_ASSERT_IMPL(a_fill, clk, rst, m_axis_tvalid, m_axis_tdata[39:35] == 5'd0)
endmodule

>>> test/tb_sha256_hash_engine_top.sv
// Testbench for the SHA-256 hash engine: random and directed messages, digest checking.
// Holds its own SHA-256 predictor; depends on sha_pkg and sha256_hash_engine_top.
`timescale 1ns / 1ps
module tb_sha256_hash_engine_top import sha_pkg::*;;

  typedef struct packed {
    logic        finish;
    logic [31:0] word;
    logic [2:0]  nbytes;
  } msg_req_t;

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  localparam logic [31:0] Kc [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] H0 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam int NumRandom = 336;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;

  // Predictor state
  logic [31:0] hash_q [8];
  logic [7:0]  blk_q [64];
  logic [63:0] bits_q;
  logic [5:0]  fill_q;

  msg_req_t pending_reqs [$];
  digest_t  expected_digests [$];
  int errors = 0;
  bit stim_done = 1'b0;

  sha256_hash_engine_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Fold the current block into the running hash
  function automatic void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + Kc[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endfunction

  function automatic void reload_hash();
    for (int i = 0; i < 8; i++) hash_q[i] = H0[i];
    bits_q = '0;
    fill_q = '0;
  endfunction

  // Absorb bytes or pad and queue the eight digest words
  function automatic void predict_digest(msg_req_t r);
    int n;
    int p;
    digest_t d;
    if (!r.finish) begin
      n = (r.nbytes > 4) ? 4 : r.nbytes;
      for (int i = 0; i < n; i++) begin
        blk_q[fill_q] = r.word[31-8*i -: 8];
        fill_q++;
        bits_q += 64'd8;
        if (fill_q == 0) compress();
      end
      return;
    end
    p = fill_q;
    blk_q[p] = PadByte;
    p++;
    if (p > 56) begin
      for (int i = p; i < 64; i++) blk_q[i] = 8'h00;
      compress();
      p = 0;
    end
    for (int i = p; i < 56; i++) blk_q[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk_q[56+i] = bits_q[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.digest = hash_q[i];
      d.index = 3'(i);
      d.last = (i == 7);
      expected_digests.push_back(d);
    end
    reload_hash();
  endfunction

  function automatic void add_absorb(logic [31:0] w, logic [2:0] n);
    msg_req_t r;
    r.finish = 1'b0; r.word = w; r.nbytes = n;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_finish(logic [31:0] w, logic [2:0] n);
    msg_req_t r;
    r.finish = 1'b1; r.word = w; r.nbytes = n;
    pending_reqs.push_back(r);
  endfunction

  // Driver: hold each request for a random gap, then present it
  int gap_in = 0;
  always @(posedge clk) begin
    msg_req_t r;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = pending_reqs.pop_front();
        predict_digest(r);
        gap_in = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
      if ((!s_axis_tvalid || s_axis_tready) && gap_in > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_in--;
      end else if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && !(s_axis_tvalid && pending_reqs.size() == 0)) begin
          r = pending_reqs[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= r.finish;
          s_axis_tdata <= {5'b0, r.nbytes, r.word};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and field checks
  int gap_out = 0;
  always @(posedge clk) begin
    digest_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digests.size() == 0) begin
          $error("unexpected digest word %h", m_axis_tdata[31:0]);
          errors++;
        end else begin
          e = expected_digests.pop_front();
          if (m_axis_tdata[31:0] !== e.digest) begin
            $error("digest_word expected %h actual %h", e.digest, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[34:32] !== e.index) begin
            $error("word_index expected %0d actual %0d", e.index, m_axis_tdata[34:32]);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_word expected %0d actual %0d", e.last, m_axis_tlast);
            errors++;
          end
        end
        gap_out = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
      if (gap_out > 0) begin
        m_axis_tready <= 1'b0;
        gap_out--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int len;
    int kind;
    reload_hash();
    for (int i = 0; i < 64; i++) blk_q[i] = 8'h00;
    // Directed: empty message, extremes, zero and oversize byte counts
    add_finish(32'hffffffff, 3'd7);
    add_absorb(32'h61626300, 3'd3);
    add_finish(32'h0, 3'd0);
    add_absorb(32'hffffffff, 3'd4);
    add_absorb(32'h00000000, 3'd0);
    add_absorb(32'hdeadbeef, 3'd7);
    add_absorb(32'h12345678, 3'd5);
    add_absorb(32'h80000000, 3'd1);
    add_absorb(32'h0000ffff, 3'd2);
    add_absorb(32'h00000000, 3'd6);
    add_finish(32'h0, 3'd4);
    // 55 and 56 bytes pending: one and two padding blocks
    for (int i = 0; i < 13; i++) add_absorb(32'ha5a5a5a5, 3'd4);
    add_absorb(32'h5a5a5a00, 3'd3);
    add_finish(32'h0, 3'd0);
    for (int i = 0; i < 14; i++) add_absorb(32'h3c3c3c3c, 3'd4);
    add_finish(32'h0, 3'd0);
    // Random messages, mostly short with occasional multi-block ones
    for (int n = 0; n < NumRandom; n += len + 1) begin
      kind = $urandom_range(0, 9);
      len = (kind == 0) ? $urandom_range(16, 40) : $urandom_range(0, 14);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) add_absorb($urandom, 3'($urandom_range(0, 7)));
        else add_absorb($urandom, 3'($urandom_range(1, 4)));
      end
      add_finish($urandom, 3'($urandom_range(0, 7)));
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (expected_digests.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_digests.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/sha_pkg.sv
hdl/sha_front.sv
hdl/sha_back.sv
hdl/sha256_hash_engine_top.sv
test/tb_sha256_hash_engine_top.sv
